[rtl/framed_packet_receiver_core_defines.svh]
// Assertion helpers for the frame receiver.
`ifndef FRAMED_PACKET_RECEIVER_CORE_DEFINES_SVH
`define FRAMED_PACKET_RECEIVER_CORE_DEFINES_SVH

// Same-cycle implication.
`define FPR_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define FPR_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/fpr_pkg.sv]
package fpr_pkg;

   localparam logic [7:0] CH_U       = 8'h55;
   localparam logic [7:0] CH_N       = 8'h4E;
   localparam logic [7:0] CH_E       = 8'h45;
   localparam logic [7:0] CH_R       = 8'h52;
   localparam logic [7:0] CH_COLON   = 8'h3A;
   localparam logic [7:0] CH_PLUS    = 8'h2B;
   localparam logic [7:0] CH_AMP     = 8'h26;
   localparam logic [7:0] CH_D       = 8'h44;
   localparam logic [7:0] CH_B       = 8'h42;
   localparam logic [7:0] CH_G       = 8'h47;
   localparam logic [7:0] CH_NEWLINE = 8'h0A;

   // XOR of the fixed header bytes, seeds the checksum together with the length
   localparam logic [7:0] HDR_XOR = CH_U ^ CH_N ^ CH_E ^ CH_R ^ CH_COLON;

   localparam logic [7:0] TIMEOUT_RESET = 8'd5;
   localparam logic [7:0] POS_MAX       = 8'hFF;

   localparam logic FUNC_BYTE = 1'b0;
   localparam logic FUNC_TICK = 1'b1;

   typedef enum logic [2:0] {
      KIND_PAYLOAD = 3'd0,
      KIND_OK      = 3'd1,
      KIND_CKSERR  = 3'd2,
      KIND_TEXT    = 3'd3,
      KIND_LINEEND = 3'd4,
      KIND_TIMEOUT = 3'd5
   } kind_type;

   typedef enum logic [11:0] {
      ST_IDLE  = 12'b0000_0000_0001,
      ST_N     = 12'b0000_0000_0010,
      ST_E     = 12'b0000_0000_0100,
      ST_R     = 12'b0000_0000_1000,
      ST_LEN   = 12'b0000_0001_0000,
      ST_COLON = 12'b0000_0010_0000,
      ST_PAY   = 12'b0000_0100_0000,
      ST_AMP   = 12'b0000_1000_0000,
      ST_D     = 12'b0001_0000_0000,
      ST_B     = 12'b0010_0000_0000,
      ST_G     = 12'b0100_0000_0000,
      ST_TEXT  = 12'b1000_0000_0000
   } parse_state_type;

   typedef struct packed {
      logic       func;
      logic [7:0] data_byte;
   } req_word_type;

   typedef struct packed {
      logic       valid;
      kind_type   kind;
      logic [7:0] value;
      logic [7:0] position;
   } rsp_word_type;

endpackage

[rtl/fpr_in_stage.sv]
module fpr_in_stage
   import fpr_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  req_word_type req_word,
   output logic         req_stall,
   input  logic         advance,
   output logic         word_valid,
   output req_word_type word
);

   logic         valid_ff, valid_in;
   req_word_type word_ff, word_in;

   // hold the word while the output side cannot take its result
   assign req_stall = valid_ff && !advance;

   always_comb begin
      valid_in = valid_ff;
      word_in  = word_ff;
      if (!req_stall) begin
         valid_in = req_valid;
         if (req_valid) begin
            word_in = req_word;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      word_ff <= word_in;
   end

   assign word_valid = valid_ff;
   assign word       = word_ff;

endmodule

[rtl/fpr_parser.sv]
module fpr_parser
   import fpr_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic [7:0]   timeout_ticks,
   input  logic         step,
   input  req_word_type word,
   output rsp_word_type result
);

   parse_state_type state_ff, state_in, restart_state;
   logic [7:0] remaining_ff, remaining_in;
   logic [7:0] xor_ff, xor_in;
   logic [7:0] pos_ff, pos_in;
   logic [7:0] ticks_ff, ticks_in;
   logic [7:0] b, rem_dec, pos_bump;

   assign b        = word.data_byte;
   assign rem_dec  = remaining_ff - 8'd1;
   assign pos_bump = (pos_ff == POS_MAX) ? pos_ff : pos_ff + 8'd1;

   // a byte that breaks a header is looked at again as a frame start
   always_comb begin
      if (b == CH_U) begin
         restart_state = ST_N;
      end else if (b == CH_PLUS) begin
         restart_state = ST_AMP;
      end else begin
         restart_state = ST_IDLE;
      end
   end

   always_comb begin
      state_in     = state_ff;
      remaining_in = remaining_ff;
      xor_in       = xor_ff;
      pos_in       = pos_ff;
      ticks_in     = ticks_ff;
      result       = '{valid: 1'b0, kind: KIND_PAYLOAD, value: 8'd0, position: 8'd0};

      if (step && word.func == FUNC_TICK) begin
         if (state_ff != ST_IDLE) begin
            if (ticks_ff <= 8'd1) begin
               ticks_in = 8'd0;
               state_in = ST_IDLE;
               result   = '{valid: 1'b1, kind: KIND_TIMEOUT, value: 8'd0, position: 8'd0};
            end else begin
               ticks_in = ticks_ff - 8'd1;
            end
         end
      end else if (step) begin
         case (state_ff)
            ST_LEN: begin
               remaining_in = b;
               state_in     = ST_COLON;
            end
            ST_PAY: begin
               remaining_in = rem_dec;
               if (rem_dec != 8'd0) begin
                  xor_in = xor_ff ^ b;
                  pos_in = pos_bump;
                  result = '{valid: 1'b1, kind: KIND_PAYLOAD, value: b, position: pos_ff};
               end else begin
                  state_in = ST_IDLE;
                  result   = '{valid: 1'b1,
                               kind: (xor_ff == b) ? KIND_OK : KIND_CKSERR,
                               value: b, position: pos_ff};
               end
            end
            ST_TEXT: begin
               if (b == CH_NEWLINE) begin
                  state_in = ST_IDLE;
                  result   = '{valid: 1'b1, kind: KIND_LINEEND, value: CH_NEWLINE,
                               position: pos_ff};
               end else begin
                  pos_in = pos_bump;
                  result = '{valid: 1'b1, kind: KIND_TEXT, value: b, position: pos_ff};
               end
            end
            ST_IDLE, ST_N, ST_E, ST_R, ST_COLON, ST_AMP, ST_D, ST_B, ST_G: begin
               // header bytes: advance on match, else restart on this byte
               if      (state_ff == ST_N     && b == CH_N)     state_in = ST_E;
               else if (state_ff == ST_E     && b == CH_E)     state_in = ST_R;
               else if (state_ff == ST_R     && b == CH_R)     state_in = ST_LEN;
               else if (state_ff == ST_AMP   && b == CH_AMP)   state_in = ST_D;
               else if (state_ff == ST_D     && b == CH_D)     state_in = ST_B;
               else if (state_ff == ST_B     && b == CH_B)     state_in = ST_G;
               else if (state_ff == ST_COLON && b == CH_COLON) begin
                  state_in = ST_PAY;
                  pos_in   = 8'd0;
                  xor_in   = HDR_XOR ^ remaining_ff;
               end else if (state_ff == ST_G && b == CH_G) begin
                  state_in = ST_TEXT;
                  pos_in   = 8'd0;
               end else begin
                  state_in = restart_state;
                  if (restart_state != ST_IDLE) begin
                     ticks_in = timeout_ticks;
                  end
               end
            end
            default: begin
               state_in = ST_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         remaining_ff <= 8'd0;
         xor_ff       <= 8'd0;
         pos_ff       <= 8'd0;
         ticks_ff     <= 8'd0;
      end else begin
         state_ff     <= state_in;
         remaining_ff <= remaining_in;
         xor_ff       <= xor_in;
         pos_ff       <= pos_in;
         ticks_ff     <= ticks_in;
      end
   end

endmodule

[rtl/fpr_out_stage.sv]
module fpr_out_stage
   import fpr_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  rsp_word_type result,
   input  logic         step,
   input  logic         rsp_stall,
   output logic         advance,
   output logic         rsp_valid,
   output logic [2:0]   rsp_kind,
   output logic [7:0]   rsp_value,
   output logic [7:0]   rsp_position
);

   logic         valid_ff, valid_in;
   rsp_word_type word_ff, word_in;

   // register is free when empty or being taken this cycle
   assign advance = !valid_ff || !rsp_stall;

   always_comb begin
      valid_in = valid_ff;
      word_in  = word_ff;
      if (advance) begin
         valid_in = step && result.valid;
         word_in  = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      word_ff <= word_in;
   end

   assign rsp_valid    = valid_ff;
   assign rsp_kind     = word_ff.kind;
   assign rsp_value    = word_ff.value;
   assign rsp_position = word_ff.position;

endmodule

[rtl/framed_packet_receiver_core.sv]
// Frame receiver for a serial byte stream.
// Input channel (req_): one word per handshake, req_func = 0 carries a received
// byte in req_data_byte, req_func = 1 is a timer tick. Accepted when req_valid
// is high and req_stall low.
// Result channel (rsp_): at most one word per input word: payload/text bytes
// with their position, and one closing word per frame (ok, checksum error,
// line end, timeout abort). Taken when rsp_valid is high and rsp_stall low.
// Config: csr_write_enable/csr_write_data load the timeout in ticks; write it
// only while no frame traffic is in flight.
// Path: an accepted word waits in the input register, then its result goes
// through the parse logic into the output register and is presented on rsp_.
// Throughput: one word per cycle while rsp_stall does not hold a result, set by the parser state update.
// Reset: parser goes idle, both registers empty, timeout back to 5 ticks.
// Stall: while rsp_stall holds a result, no word moves through the parser; an
// empty input register still absorbs one further word, then req_stall rises
// and holds until the result is taken.
module framed_packet_receiver_core
   import fpr_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic       req_func,
   input  logic [7:0] req_data_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [2:0] rsp_kind,
   output logic [7:0] rsp_value,
   output logic [7:0] rsp_position,
   input  logic       csr_write_enable,
   input  logic [7:0] csr_write_data
);

   logic [7:0]   timeout_ticks_ff, timeout_ticks_in;
   logic         advance;
   logic         word_valid;
   logic         step;
   req_word_type req_word;
   req_word_type word;
   rsp_word_type result;

   assign timeout_ticks_in = csr_write_enable ? csr_write_data : timeout_ticks_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ticks_ff <= TIMEOUT_RESET;
      end else begin
         timeout_ticks_ff <= timeout_ticks_in;
      end
   end

   assign req_word = '{func: req_func, data_byte: req_data_byte};

   // the parser steps whenever the held word moves on
   assign step = word_valid && advance;

   fpr_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_word   (req_word),
      .req_stall  (req_stall),
      .advance    (advance),
      .word_valid (word_valid),
      .word       (word)
   );

   fpr_parser u_parser (
      .clock         (clock),
      .reset         (reset),
      .timeout_ticks (timeout_ticks_ff),
      .step          (step),
      .word          (word),
      .result        (result)
   );

   fpr_out_stage u_out_stage (
      .clock        (clock),
      .reset        (reset),
      .result       (result),
      .step         (step),
      .rsp_stall    (rsp_stall),
      .advance      (advance),
      .rsp_valid    (rsp_valid),
      .rsp_kind     (rsp_kind),
      .rsp_value    (rsp_value),
      .rsp_position (rsp_position)
   );

endmodule

[rtl/fpr_checker.sv]
`include "framed_packet_receiver_core_defines.svh"

module fpr_checker
   import fpr_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [2:0] rsp_kind,
   input logic [7:0] rsp_value,
   input logic [7:0] rsp_position
);

   logic [18:0] rsp_word;
   logic        rsp_held;
   logic        rsp_idle;
   logic        timeout_word;
   logic        lineend_word;
   logic        rsp_fields_zero;

   assign rsp_word        = {rsp_kind, rsp_value, rsp_position};
   assign rsp_held        = rsp_valid && rsp_stall;
   assign rsp_idle        = !rsp_valid && !req_stall;
   assign timeout_word    = rsp_valid && rsp_kind == KIND_TIMEOUT;
   assign lineend_word    = rsp_valid && rsp_kind == KIND_LINEEND;
   assign rsp_fields_zero = rsp_value == 8'd0 && rsp_position == 8'd0;

   `FPR_ASSERT_NOW(a_kind_known, clock, reset, rsp_valid, rsp_kind <= KIND_TIMEOUT, "bad kind")
   `FPR_ASSERT_NOW(a_timeout_zero, clock, reset, timeout_word, rsp_fields_zero, "timeout not zero")
   `FPR_ASSERT_NOW(a_lineend_nl, clock, reset, lineend_word, rsp_value == CH_NEWLINE, "bad line end")
   `FPR_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_held, rsp_valid && $stable(rsp_word), "result moved")
   `FPR_ASSERT_NOW(a_reset_empty, clock, 1'b0, $past(reset) && !reset, rsp_idle, "busy after reset")

endmodule

bind framed_packet_receiver_core fpr_checker u_fpr_checker (
   .clock        (clock),
   .reset        (reset),
   .req_stall    (req_stall),
   .rsp_valid    (rsp_valid),
   .rsp_stall    (rsp_stall),
   .rsp_kind     (rsp_kind),
   .rsp_value    (rsp_value),
   .rsp_position (rsp_position)
);
